### rtl/vendor_ie_ack_extractor_top_macros.svh
// assertion macros for the vendor ie ack extractor
// expects clk and arst_n in the scope of the module that uses them
`ifndef VENDOR_IE_ACK_EXTRACTOR_TOP_MACROS_SVH
`define VENDOR_IE_ACK_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication
`define VIE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/vie_pkg.sv
// shared types and constants for the vendor ie ack extractor
// no dependencies
`default_nettype none

package vie_pkg;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_VENDOR_TAG = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_VENDOR_OUI = 1'b1;

	localparam logic [7:0] VENDOR_TAG_RST = 8'd221;
	localparam logic [23:0] VENDOR_OUI_RST = 24'h010203;

	localparam logic [7:0] MIN_VENDOR_LEN = 8'd4;
	localparam logic [7:0] OUI_BYTES = 8'd3;

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		WALK_TAG  = 3'b001,
		WALK_LEN  = 3'b010,
		WALK_BODY = 3'b100
	} walk_phase_t;

	typedef enum logic [2:0] {
		TEXT_SKIP   = 3'b001,
		TEXT_DIGITS = 3'b010,
		TEXT_DONE   = 3'b100
	} text_phase_t;

	typedef struct packed {
		logic [7:0]  vendor_tag;
		logic [23:0] vendor_oui;
	} cfg_t;

	typedef struct packed {
		logic       clear;
		logic       feed;
		logic [7:0] ch;
	} text_ctl_t;

endpackage

`default_nettype wire

### rtl/vie_ifs.sv
// request channel interfaces for blob bytes and ack results
// no dependencies
`default_nettype none

interface vie_blob_if;
	logic       valid;
	logic       ready;
	logic [7:0] blob_byte;
	logic       blob_end;

	modport source (output valid, output blob_byte, output blob_end, input ready);
	modport sink (input valid, input blob_byte, input blob_end, output ready);
endinterface

interface vie_ack_if;
	logic               valid;
	logic               ready;
	logic               ack_found;
	logic signed [31:0] ack_number;

	modport source (output valid, output ack_found, output ack_number, input ready);
	modport sink (input valid, input ack_found, input ack_number, output ready);
endinterface

`default_nettype wire

### rtl/vie_cfg_regs.sv
// apb configuration registers: vendor tag and vendor oui
// depends on vie_pkg
`default_nettype none

module vie_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vie_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output vie_pkg::cfg_t                     cfg
);

	logic [7:0]  tag_q;
	logic [23:0] oui_q;
	logic        wr_en;
	logic [vie_pkg::REG_IDX_W-1:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[vie_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= vie_pkg::VENDOR_TAG_RST;
			oui_q <= vie_pkg::VENDOR_OUI_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				vie_pkg::REG_VENDOR_TAG: tag_q <= pwdata[7:0];
				vie_pkg::REG_VENDOR_OUI: oui_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			vie_pkg::REG_VENDOR_TAG: prdata = {24'd0, tag_q};
			vie_pkg::REG_VENDOR_OUI: prdata = {8'd0, oui_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.vendor_tag = tag_q;
	assign cfg.vendor_oui = oui_q;

endmodule

`default_nettype wire

### rtl/vie_atoi.sv
// decimal text reader: blanks, optional sign, saturating digit accumulate
// depends on vie_pkg
`default_nettype none

module vie_atoi (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  vie_pkg::text_ctl_t     ctl,
	output logic signed [31:0]     value
);

	vie_pkg::text_phase_t phase_q, phase_d;
	logic        neg_q, neg_d;
	logic [31:0] mag_q, mag_d;
	logic        blank, digit, sign_taken;
	logic [35:0] prod;

	assign blank = (ctl.ch == vie_pkg::CH_SPACE) ||
		((ctl.ch >= vie_pkg::CH_TAB) && (ctl.ch <= vie_pkg::CH_CR));
	assign digit = (ctl.ch >= vie_pkg::CH_ZERO) && (ctl.ch <= vie_pkg::CH_NINE);
	assign prod = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} +
		{32'd0, ctl.ch[3:0]};

	always_comb begin
		phase_d = phase_q;
		neg_d = neg_q;
		mag_d = mag_q;
		sign_taken = 1'b0;
		if (ctl.feed) begin
			if ((phase_q == vie_pkg::TEXT_SKIP) && !blank) begin
				phase_d = vie_pkg::TEXT_DIGITS;
				if ((ctl.ch == vie_pkg::CH_PLUS) || (ctl.ch == vie_pkg::CH_MINUS)) begin
					neg_d = (ctl.ch == vie_pkg::CH_MINUS);
					sign_taken = 1'b1;
				end
			end
			if ((phase_d == vie_pkg::TEXT_DIGITS) && !sign_taken) begin
				if (digit) begin
					mag_d = (prod > {4'd0, vie_pkg::MAG_LIMIT}) ?
						vie_pkg::MAG_LIMIT : prod[31:0];
				end else begin
					phase_d = vie_pkg::TEXT_DONE;
				end
			end
		end
	end

	// value as settled after this byte
	always_comb begin
		if (neg_d) begin
			value = signed'(32'd0 - mag_d);
		end else begin
			value = signed'(mag_d[31] ? vie_pkg::POS_MAX : mag_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vie_pkg::TEXT_SKIP;
			neg_q <= 1'b0;
			mag_q <= '0;
		end else if (ctl.clear) begin
			phase_q <= vie_pkg::TEXT_SKIP;
			neg_q <= 1'b0;
			mag_q <= '0;
		end else begin
			phase_q <= phase_d;
			neg_q <= neg_d;
			mag_q <= mag_d;
		end
	end

endmodule

`default_nettype wire

### rtl/vendor_ie_ack_extractor_top.sv
// Vendor IE ack extractor, top level.
// Depends on vie_pkg, vie_ifs, vie_cfg_regs, vie_atoi and the macros header.
//
// Usage:
//   blob (sink): one byte of an information-element blob per request, with
//     blob_end on the last byte. Elements are walked as tag, length, body.
//   ack (source): one request per blob, issued after its last byte, with
//     ack_found and the stored ack_number (kept from earlier blobs if no
//     complete matching vendor element was seen).
//   apb: vendor_tag at 0x0, vendor_oui at 0x4; write only while idle.
// Timing:
//   a byte is registered in the input register on accept and processed as it
//   leaves, which for a blob-end byte also loads the result register for ack.
//   One byte per cycle is sustained while no result is held on ack, limited by
//   the single walker update per cycle.
// Reset: registers return to tag 221 and oui 0x010203, the stored number to
//   zero and the walk to expecting a tag byte.
// Stall: a result held on ack blocks only the next blob-end byte, which waits
//   in the input register and holds off further bytes until ack is taken.
`default_nettype none
`include "vendor_ie_ack_extractor_top_macros.svh"

module vendor_ie_ack_extractor_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	vie_blob_if.sink                          blob,
	vie_ack_if.source                         ack,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vie_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	vie_pkg::cfg_t      cfg;
	vie_pkg::text_ctl_t text_ctl;
	logic signed [31:0] text_value;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        go;

	vie_pkg::walk_phase_t walk_q, walk_d;
	logic [7:0]  tag_q, tag_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  pos_q, pos_d;
	logic        match_q, match_d;
	logic signed [31:0] stored_q, stored_d;
	logic        found_q, found_d, found_nx;
	logic [7:0]  oui_byte;

	logic        out_valid_q;
	logic        out_found_q;
	logic signed [31:0] out_number_q;

	vie_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vie_atoi u_atoi (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (text_ctl),
		.value  (text_value)
	);

	assign go = valid_s1 && !(end_s1 && out_valid_q && !ack.ready);
	assign blob.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (blob.valid && blob.ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (blob.valid && blob.ready) begin
			byte_s1 <= blob.blob_byte;
			end_s1 <= blob.blob_end;
		end
	end

	always_comb begin
		case (pos_q[1:0])
			2'd0: oui_byte = cfg.vendor_oui[23:16];
			2'd1: oui_byte = cfg.vendor_oui[15:8];
			default: oui_byte = cfg.vendor_oui[7:0];
		endcase
	end

	assign text_ctl.ch = byte_s1;
	assign text_ctl.feed = go && (walk_q == vie_pkg::WALK_BODY) && (pos_q >= vie_pkg::OUI_BYTES);
	assign text_ctl.clear = go && ((walk_q == vie_pkg::WALK_LEN) || end_s1);

	always_comb begin
		walk_d = walk_q;
		tag_d = tag_q;
		len_d = len_q;
		pos_d = pos_q;
		match_d = match_q;
		stored_d = stored_q;
		found_d = found_q;
		unique case (walk_q)
			vie_pkg::WALK_TAG: begin
				tag_d = byte_s1;
				walk_d = vie_pkg::WALK_LEN;
			end
			vie_pkg::WALK_LEN: begin
				len_d = byte_s1;
				pos_d = '0;
				match_d = 1'b1;
				walk_d = (byte_s1 == 8'd0) ? vie_pkg::WALK_TAG : vie_pkg::WALK_BODY;
			end
			vie_pkg::WALK_BODY: begin
				if ((pos_q < vie_pkg::OUI_BYTES) && (byte_s1 != oui_byte)) begin
					match_d = 1'b0;
				end
				if (({1'b0, pos_q} + 9'd1) >= {1'b0, len_q}) begin
					if ((tag_q == cfg.vendor_tag) && (len_q >= vie_pkg::MIN_VENDOR_LEN) &&
						match_d) begin
						stored_d = text_value;
						found_d = 1'b1;
					end
					walk_d = vie_pkg::WALK_TAG;
				end else begin
					pos_d = pos_q + 8'd1;
				end
			end
			default: walk_d = vie_pkg::WALK_TAG;
		endcase
		found_nx = found_d;
		if (end_s1) begin
			walk_d = vie_pkg::WALK_TAG;
			found_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= vie_pkg::WALK_TAG;
			found_q <= 1'b0;
			stored_q <= '0;
		end else if (go) begin
			walk_q <= walk_d;
			found_q <= found_nx;
			stored_q <= stored_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			tag_q <= tag_d;
			len_q <= len_d;
			pos_q <= pos_d;
			match_q <= match_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (ack.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && end_s1) begin
			out_found_q <= found_d;
			out_number_q <= stored_d;
		end
	end

	assign ack.valid = out_valid_q;
	assign ack.ack_found = out_found_q;
	assign ack.ack_number = out_number_q;

	`VIE_ASSERT_NEXT(a_result_only_on_end, !(valid_s1 && end_s1), !$rose(out_valid_q), "result without blob end")
	`VIE_ASSERT_NEXT(a_walk_restarts, go && end_s1, (walk_q == vie_pkg::WALK_TAG) && !found_q, "walk not restarted after blob end")
	`VIE_ASSERT_NOW(a_no_overwrite, out_valid_q && !ack.ready && valid_s1 && end_s1, !go, "held result overwritten")
	`VIE_ASSERT_NOW(a_pos_in_body, walk_q == vie_pkg::WALK_BODY, pos_q < len_q, "body position past element length")

endmodule

`default_nettype wire

### tb/sv/ack_extract_checker.sv
`timescale 1ns / 100ps
// checker for the vendor ie ack extractor: follows accepted blob bytes and register
// writes, predicts each ack request and compares it field by field on arrival
// depends on vie_pkg and the vie_blob_if / vie_ack_if interfaces
module ack_extract_checker import vie_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	vie_blob_if                     blob,
	vie_ack_if                      ack,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	output int                      fail_count,
	output int                      pending
);

	typedef struct {
		logic               found;
		logic signed [31:0] number;
	} ack_result_t;

	ack_result_t acks_due[$];

	logic [7:0]         cfg_tag = VENDOR_TAG_RST;
	logic [23:0]        cfg_oui = VENDOR_OUI_RST;
	walk_phase_t        walk = WALK_TAG;
	text_phase_t        txt = TEXT_SKIP;
	logic [7:0]         el_tag = '0;
	logic [7:0]         el_len = '0;
	logic [7:0]         body_pos = '0;
	logic               oui_ok = 1'b0;
	logic               negative = 1'b0;
	logic               found = 1'b0;
	logic [31:0]        magnitude = '0;
	logic signed [31:0] stored_ack = '0;

	function automatic void clear_walk();
		walk = WALK_TAG;
		el_tag = '0;
		el_len = '0;
		body_pos = '0;
		oui_ok = 1'b0;
		txt = TEXT_SKIP;
		negative = 1'b0;
		magnitude = '0;
		found = 1'b0;
	endfunction

	function automatic void walk_ie_byte(input logic [7:0] b, input logic last);
		int          shift;
		logic [31:0] digit;
		logic        sign_byte;
		sign_byte = 1'b0;
		case (walk)
			WALK_TAG: begin
				el_tag = b;
				walk = WALK_LEN;
			end
			WALK_LEN: begin
				el_len = b;
				body_pos = '0;
				oui_ok = 1'b1;
				txt = TEXT_SKIP;
				negative = 1'b0;
				magnitude = '0;
				walk = (b == 8'd0) ? WALK_TAG : WALK_BODY;
			end
			default: begin
				if (body_pos < OUI_BYTES) begin
					shift = 16 - 8 * int'(body_pos);
					if (b != cfg_oui[shift +: 8])
						oui_ok = 1'b0;
				end else begin
					// atoi style: blanks, optional sign, digits up to the first other byte
					if (txt == TEXT_SKIP && !(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
						txt = TEXT_DIGITS;
						if (b == CH_PLUS || b == CH_MINUS) begin
							negative = (b == CH_MINUS);
							sign_byte = 1'b1;
						end
					end
					if (txt == TEXT_DIGITS && !sign_byte) begin
						if (b >= CH_ZERO && b <= CH_NINE) begin
							digit = 32'(b - CH_ZERO);
							if (magnitude > (MAG_LIMIT - digit) / 32'd10)
								magnitude = MAG_LIMIT;
							else
								magnitude = magnitude * 32'd10 + digit;
						end else begin
							txt = TEXT_DONE;
						end
					end
				end
				if (int'(body_pos) + 1 >= int'(el_len)) begin
					if (el_tag == cfg_tag && el_len >= MIN_VENDOR_LEN && oui_ok) begin
						stored_ack = negative ? (32'd0 - magnitude)
							: ((magnitude > POS_MAX) ? POS_MAX : magnitude);
						found = 1'b1;
					end
					walk = WALK_TAG;
				end else begin
					body_pos = body_pos + 8'd1;
				end
			end
		endcase
		if (last) begin
			acks_due.push_back('{found, stored_ack});
			clear_walk();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ack_result_t due;
		if (!arst_n) begin
			cfg_tag = VENDOR_TAG_RST;
			cfg_oui = VENDOR_OUI_RST;
			stored_ack = '0;
			clear_walk();
			acks_due.delete();
			fail_count = 0;
		end else begin
			if (ack.valid && ack.ready) begin
				if (acks_due.size() == 0) begin
					$error("unexpected ack request: ack_found %0b ack_number %0d",
						ack.ack_found, ack.ack_number);
					fail_count++;
				end else begin
					due = acks_due.pop_front();
					if (ack.ack_found !== due.found) begin
						$error("ack_found expected %0b got %0b", due.found, ack.ack_found);
						fail_count++;
					end
					if (ack.ack_number !== due.number) begin
						$error("ack_number expected %0d got %0d", due.number, ack.ack_number);
						fail_count++;
					end
				end
			end
			if (blob.valid && blob.ready)
				walk_ie_byte(blob.blob_byte, blob.blob_end);
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_VENDOR_TAG: cfg_tag = pwdata[7:0];
					REG_VENDOR_OUI: cfg_oui = pwdata[23:0];
					default: ;
				endcase
			end
		end
		pending = acks_due.size();
	end

endmodule

### tb/sv/tb_vendor_ie_ack_extractor_top.sv
`timescale 1ns / 100ps
// top of the vendor ie ack extractor testbench: drives element blobs, register writes
// and ack back-pressure, and gives the verdict from the checker's failure count
// depends on vie_pkg, vie_ifs, ack_extract_checker and vendor_ie_ack_extractor_top
module tb_vendor_ie_ack_extractor_top;
	import vie_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;

	typedef enum {EL_VENDOR, EL_BAD_OUI, EL_SHORT, EL_OTHER, EL_EMPTY} elem_kind_t;
	typedef enum {RDY_OPEN, RDY_COIN, RDY_SPARSE, RDY_BURSTY} ready_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 fail_count;
	int                 pending;

	vie_blob_if byte_ch();
	vie_ack_if  ack_ch();

	vendor_ie_ack_extractor_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.blob    (byte_ch),
		.ack     (ack_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ack_extract_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.blob       (byte_ch),
		.ack        (ack_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [7:0]  blob_bytes[$];
	logic [7:0]  cfg_tag_now = VENDOR_TAG_RST;
	logic [23:0] cfg_oui_now = VENDOR_OUI_RST;
	int          burst_left = 0;
	int          bytes_sent = 0;
	int          blobs_sent = 0;
	int          cycle_count = 0;
	int          phase_bytes;
	int          phase_blobs;
	int          r;
	int          k;
	int          keep;
	bit          long_hold_go = 1'b0;
	bit          long_hold_done = 1'b0;
	int          hold_left = 0;
	int          mode_left = 0;
	ready_mode_t ready_mode = RDY_OPEN;

	// ack back-pressure: one long hold on request, otherwise changing patterns
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			ack_ch.ready <= 1'b0;
		end else if (long_hold_go && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			ack_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (ready_mode)
				RDY_OPEN: ack_ch.ready <= 1'b1;
				RDY_COIN: ack_ch.ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: ack_ch.ready <= ($urandom_range(0, 3) == 0);
				default: begin
					if ($urandom_range(0, 9) == 0) begin
						hold_left = $urandom_range(3, 15);
						ack_ch.ready <= 1'b0;
					end else begin
						ack_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drive_byte(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			if (byte_ch.valid) begin
				byte_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 5))
					@(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.blob_byte <= b;
		byte_ch.blob_end <= last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic send_blob();
		for (int i = 0; i < blob_bytes.size(); i++)
			drive_byte(blob_bytes[i], i == blob_bytes.size() - 1);
		bytes_sent += blob_bytes.size();
		blobs_sent++;
	endtask

	// stop offering bytes and wait until every ack request has come
	task automatic go_idle();
		byte_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	function automatic void build_element(input elem_kind_t kind);
		logic [7:0] body[$];
		logic [7:0] tag;
		string      lim;
		int         n;
		int         sel;
		body = {};
		tag = 8'($urandom_range(0, 255));
		case (kind)
			EL_VENDOR, EL_BAD_OUI, EL_SHORT: begin
				tag = cfg_tag_now;
				body.push_back(cfg_oui_now[23:16]);
				body.push_back(cfg_oui_now[15:8]);
				body.push_back(cfg_oui_now[7:0]);
				if (kind == EL_BAD_OUI) begin
					sel = $urandom_range(0, 2);
					body[sel] = body[sel] ^ (8'd1 << $urandom_range(0, 7));
				end
				if (kind == EL_SHORT) begin
					n = $urandom_range(0, 3);
					while (body.size() > n)
						void'(body.pop_back());
				end else begin
					if ($urandom_range(0, 3) == 0) begin
						n = $urandom_range(1, 3);
						repeat (n) begin
							sel = $urandom_range(0, 5);
							body.push_back((sel == 5) ? CH_SPACE : CH_TAB + 8'(sel));
						end
					end
					sel = $urandom_range(0, 3);
					if (sel == 0)
						body.push_back(CH_PLUS);
					else if (sel == 1)
						body.push_back(CH_MINUS);
					sel = $urandom_range(0, 9);
					if (sel == 1) begin
						case ($urandom_range(0, 2))
							0: lim = "2147483647";
							1: lim = "2147483648";
							default: lim = "99999999999";
						endcase
						for (int i = 0; i < lim.len(); i++)
							body.push_back(8'(lim[i]));
					end else if (sel != 0) begin
						n = (sel == 2) ? $urandom_range(10, 14) : $urandom_range(1, 9);
						repeat (n)
							body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					end
					n = $urandom_range(0, 3);
					repeat (n)
						body.push_back(($urandom_range(0, 4) == 0) ? 8'h00
							: 8'($urandom_range(0, 255)));
				end
			end
			EL_OTHER: begin
				n = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255)
					: $urandom_range(0, 10);
				repeat (n)
					body.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				if ($urandom_range(0, 1) == 0)
					tag = cfg_tag_now;
			end
		endcase
		blob_bytes.push_back(tag);
		blob_bytes.push_back(8'(body.size()));
		foreach (body[i])
			blob_bytes.push_back(body[i]);
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.blob_byte = '0;
		byte_ch.blob_end = 1'b0;
		ack_ch.ready = 1'b0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(REG_VENDOR_TAG, {24'd0, VENDOR_TAG_RST});
		reg_write(REG_VENDOR_OUI, {8'd0, VENDOR_OUI_RST});

		// tag cut short
		blob_bytes = '{8'hFF};
		send_blob();
		// empty vendor element, then a lone tag
		blob_bytes = '{VENDOR_TAG_RST, 8'd0, 8'd0};
		send_blob();
		// sign with no digits
		blob_bytes = '{VENDOR_TAG_RST, 8'd4, VENDOR_OUI_RST[23:16], VENDOR_OUI_RST[15:8],
			VENDOR_OUI_RST[7:0], CH_PLUS};
		send_blob();
		// blank, minus, digit, zero byte as stop
		blob_bytes = '{VENDOR_TAG_RST, 8'd7, VENDOR_OUI_RST[23:16], VENDOR_OUI_RST[15:8],
			VENDOR_OUI_RST[7:0], CH_SPACE, CH_MINUS, CH_ZERO + 8'd9, 8'h00};
		send_blob();
		// body cut short keeps the old number
		blob_bytes = '{VENDOR_TAG_RST, 8'd6, VENDOR_OUI_RST[23:16], VENDOR_OUI_RST[15:8],
			VENDOR_OUI_RST[7:0], CH_ZERO + 8'd1};
		send_blob();

		for (int p = 0; p < 5; p++) begin
			go_idle();
			case (p)
				0: begin
					cfg_tag_now = 8'd0;
					cfg_oui_now = 24'h000000;
				end
				1: begin
					cfg_tag_now = 8'hFF;
					cfg_oui_now = 24'hFFFFFF;
				end
				4: begin
					cfg_tag_now = VENDOR_TAG_RST;
					cfg_oui_now = VENDOR_OUI_RST;
				end
				default: begin
					cfg_tag_now = 8'($urandom_range(0, 255));
					cfg_oui_now = 24'($urandom_range(0, 24'hFFFFFF));
				end
			endcase
			reg_write(REG_VENDOR_TAG, {24'd0, cfg_tag_now});
			reg_write(REG_VENDOR_OUI, {8'd0, cfg_oui_now});
			if (p == 2)
				long_hold_go = 1'b1;
			phase_bytes = bytes_sent + 115;
			phase_blobs = blobs_sent + 4;
			while (bytes_sent < phase_bytes || blobs_sent < phase_blobs) begin
				blob_bytes = {};
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 8))
						blob_bytes.push_back(8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(1, 4)) begin
						r = $urandom_range(0, 19);
						build_element((r < 9) ? EL_VENDOR : (r < 12) ? EL_BAD_OUI
							: (r < 14) ? EL_SHORT : (r < 18) ? EL_OTHER : EL_EMPTY);
					end
					// trailing element cut short by the blob end
					if ($urandom_range(0, 3) == 0) begin
						k = blob_bytes.size();
						build_element(elem_kind_t'($urandom_range(0, 4)));
						keep = k + $urandom_range(1, blob_bytes.size() - k - 1);
						while (blob_bytes.size() > keep)
							void'(blob_bytes.pop_back());
					end
				end
				send_blob();
			end
		end

		go_idle();
		repeat (8)
			@(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/vie_pkg.sv
rtl/vie_ifs.sv
rtl/vie_cfg_regs.sv
rtl/vie_atoi.sv
rtl/vendor_ie_ack_extractor_top.sv
tb/sv/ack_extract_checker.sv
tb/sv/tb_vendor_ie_ack_extractor_top.sv
